// ----- design/thst_pkg.sv -----
// thst_pkg: types, constants and tables shared by the strobe time blocks
// no dependencies
package thst_pkg;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_ZERO_MV = 2'd1,
    KIND_HOT     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  rank;
    logic [13:0] mv;
    logic [15:0] tfac;
    logic [8:0]  x_p;
    logic [6:0]  z_p;
  } item_t;

  localparam logic [26:0] RankK [4] = '{27'd107706608, 27'd95154588,
                                        27'd83379968, 27'd71569008};
  localparam logic [17:0] RankD [4] = '{18'd190000, 18'd177000,
                                        18'd164000, 18'd150000};

  localparam logic [13:0] VoltLow = 14'd4200;
  localparam logic [13:0] VoltUp [6] = '{14'd4500, 14'd5000, 14'd5500,
                                         14'd6000, 14'd7000, 14'd8500};
  localparam logic signed [11:0] TempLow = -12'sd50;
  localparam logic signed [11:0] TempUp [5] = '{12'sd50, 12'sd200, 12'sd350,
                                                12'sd500, 12'sd700};

  localparam logic [7:0] Corr [6][5] = '{
    '{8'd240, 8'd188, 8'd133, 8'd90, 8'd69},
    '{8'd150, 8'd121, 8'd86,  8'd53, 8'd29},
    '{8'd90,  8'd82,  8'd50,  8'd31, 8'd25},
    '{8'd63,  8'd40,  8'd31,  8'd17, 8'd17},
    '{8'd36,  8'd27,  8'd10,  8'd10, 8'd10},
    '{8'd9,   8'd5,   8'd0,   8'd0,  8'd0}
  };

endpackage

// ----- design/thst_front.sv -----
// thst_front: rank register and classification of incoming transactions
// depends on thst_pkg
module thst_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic [13:0]          supply_mv_i,
  input  logic signed [11:0]   temp_decideg_i,
  input  logic [8:0]           row_sum_i,
  output thst_pkg::item_t      item_o
);
  import thst_pkg::*;

  logic [1:0]         rank_q;
  logic signed [16:0] tfac;
  logic [2:0]         vb;
  logic [2:0]         tb;
  logic               v_ok;
  logic               t_ok;
  logic [7:0]         x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= 2'd0;
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    tfac = 17'sd12200 - 17'sd11 * 17'(temp_decideg_i);
    vb   = 3'd0;
    tb   = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (supply_mv_i <= VoltUp[i]) vb = 3'(i);
    end
    for (int i = 4; i >= 0; i--) begin
      if (temp_decideg_i <= TempUp[i]) tb = 3'(i);
    end
    v_ok = (supply_mv_i >= VoltLow) && (supply_mv_i <= VoltUp[5]);
    t_ok = (temp_decideg_i >= TempLow) && (temp_decideg_i <= TempUp[4]);
    x    = (v_ok && t_ok) ? Corr[vb][tb] : 8'd0;

    item_o.rank = rank_q;
    item_o.mv   = supply_mv_i;
    item_o.tfac = tfac[15:0];
    item_o.x_p  = 9'd100 + 9'(x);
    item_o.z_p  = 7'd100 + 7'(row_sum_i[8:6]);
    if (supply_mv_i == 14'd0) begin
      item_o.kind = KIND_ZERO_MV;
    end else if (tfac < 0) begin
      item_o.kind = KIND_HOT;
    end else begin
      item_o.kind = KIND_NORMAL;
    end
  end

endmodule

// ----- design/thst_fifo.sv -----
// thst_fifo: short queue of classified transactions between front and back
// depends on thst_pkg
module thst_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  thst_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output thst_pkg::item_t rdata_o
);
  import thst_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_rd) rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- design/thst_back.sv -----
// thst_back: multiply sequence, restoring divider and result register
// depends on thst_pkg
module thst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  thst_pkg::item_t q_item_i,
  output logic            q_rd_o,
  output logic            empty,
  input  logic            pop,
  output logic [15:0]     strobe_us_o,
  output logic            clamped_o
);
  import thst_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MUL3 = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e       state_q;
  item_t        it_q;
  logic [15:0]  a_q;
  logic [27:0]  m2_q;
  logic [31:0]  b_q;
  logic [45:0]  d_q;
  logic [58:0]  rem_q;
  logic [60:0]  dsh_q;
  logic [3:0]   cnt_q;
  logic [15:0]  res_q;
  logic         clr_q;
  logic         sat_q;
  logic         out_valid_q;
  logic [15:0]  strobe_q;
  logic         clamp_q;
  logic         ge;
  logic         load_out;

  assign ge       = {2'b0, rem_q} >= dsh_q;
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || pop);
  assign q_rd_o   = (state_q == ST_IDLE) && q_valid_i;
  assign empty    = !out_valid_q;
  assign strobe_us_o = strobe_q;
  assign clamped_o   = clamp_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        it_q <= q_item_i;
        res_q <= (q_item_i.kind == KIND_ZERO_MV) ? 16'hFFFF : 16'd0;
        clr_q <= 1'b1;
      end
      ST_MUL1: begin
        a_q  <= 16'(it_q.x_p) * 16'(it_q.z_p);
        m2_q <= 28'(it_q.mv) * 28'(it_q.mv);
      end
      ST_MUL2: begin
        b_q <= 32'(a_q) * 32'(it_q.tfac);
        d_q <= 46'(m2_q) * 46'(RankD[it_q.rank]);
      end
      ST_MUL3: begin
        rem_q <= 59'(RankK[it_q.rank]) * 59'(b_q);
      end
      ST_DIV: begin
        if (sat_q) begin
          res_q <= 16'hFFFF;
          clr_q <= 1'b1;
        end else begin
          if (ge) rem_q <= rem_q - dsh_q[58:0];
          res_q <= {res_q[14:0], ge};
          dsh_q <= dsh_q >> 1;
          clr_q <= 1'b0;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
    if (state_q == ST_MUL3) begin
      dsh_q <= {d_q, 15'b0};
      sat_q <= 1'b0;
    end
    if (state_q == ST_DIV && cnt_q == 4'd15 && !sat_q &&
        {3'b0, rem_q} >= {d_q, 16'b0}) begin
      sat_q <= 1'b1;
    end
    if (load_out) begin
      strobe_q <= res_q;
      clamp_q  <= clr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (pop && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= (q_item_i.kind == KIND_NORMAL) ? ST_MUL1 : ST_FIN;
          end
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_MUL3;
        ST_MUL3: begin
          state_q <= ST_DIV;
          cnt_q   <= 4'd15;
        end
        ST_DIV: begin
          if (sat_q || cnt_q == 4'd0) state_q <= ST_FIN;
          cnt_q <= cnt_q - 1'b1;
        end
        ST_FIN: begin
          if (load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // divider remainder stays below twice the shifted divisor
  a_div_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sat_q && cnt_q != 4'd15) |->
      ({3'b0, rem_q} < {dsh_q, 1'b0}))
    else $error("divider remainder out of range");
  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded on finish");
  a_idle_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && q_valid_i) |=> (state_q != ST_IDLE))
    else $error("queued transaction not taken");
`endif

endmodule

// ----- design/thermal_head_strobe_time_core.sv -----
// thermal_head_strobe_time_core: top level of the strobe time calculator
// depends on thst_pkg, thst_front, thst_fifo, thst_back
// One transaction gives one strobe time. A normal transaction passes in
// the back end through taking it from the queue, three multiply steps,
// sixteen restoring divide steps, one quotient bit a cycle, with the
// saturation check made in the first, and a finish step; a saturating one
// ends after the second divide step, and a zero supply or overheated head
// goes straight to the finish step. The front classifies and queues up to
// FifoDepth transactions while the back end works, and one finished result
// waits in the output register, so a new transaction is accepted every
// cycle the queue has room. The back end takes them one at a time.
module thermal_head_strobe_time_core #(
  parameter int FifoDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [13:0]        supply_mv_i,
  input  logic signed [11:0] temp_decideg_i,
  input  logic [8:0]         row_sum_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        strobe_us_o,
  output logic               clamped_o
);
  import thst_pkg::*;

  item_t f_item;
  item_t q_item;
  logic  q_valid;
  logic  q_rd;

  thst_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .supply_mv_i, .temp_decideg_i, .row_sum_i,
    .item_o (f_item)
  );

  thst_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_i    (push),
    .wdata_i (f_item),
    .full_o  (full),
    .rd_i    (q_rd),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  thst_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_rd_o    (q_rd),
    .empty, .pop, .strobe_us_o, .clamped_o
  );

endmodule

// ----- tb/tb_thermal_head_strobe_time_core.sv -----
// tb_thermal_head_strobe_time_core: self-checking bench for the strobe time core
// depends on thst_pkg and thermal_head_strobe_time_core; predicts each strobe time
// with exact integer math and compares in order, across all head ranks
module tb_thermal_head_strobe_time_core;
  import thst_pkg::*;

  typedef struct packed {
    logic [13:0]        mv;
    logic signed [11:0] temp;
    logic [8:0]         rows;
  } row_req_t;

  typedef struct packed {
    logic [15:0] us;
    logic        clamped;
  } strobe_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic full;
  logic [13:0] supply_mv_i = '0;
  logic signed [11:0] temp_decideg_i = '0;
  logic [8:0] row_sum_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] strobe_us_o;
  logic clamped_o;

  row_req_t pending_rows[$];
  strobe_t expected_strobes[$];
  logic [1:0] rank_now = '0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  logic driver_on = 1'b0;

  thermal_head_strobe_time_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full), .supply_mv_i(supply_mv_i),
    .temp_decideg_i(temp_decideg_i), .row_sum_i(row_sum_i), .empty(empty),
    .pop(pop), .strobe_us_o(strobe_us_o), .clamped_o(clamped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned corr_pct(logic [13:0] mv, logic signed [11:0] t);
    int vb;
    int tb;
    int vup[6];
    int tup[5];
    vup = '{4500, 5000, 5500, 6000, 7000, 8500};
    tup = '{50, 200, 350, 500, 700};
    vb = -1;
    tb = -1;
    if (mv >= 4200)
      for (int i = 5; i >= 0; i--) if (mv <= vup[i]) vb = i;
    if (t >= -50)
      for (int i = 4; i >= 0; i--) if (int'(t) <= tup[i]) tb = i;
    if (vb < 0 || tb < 0) return 0;
    return Corr[vb][tb];
  endfunction

  function automatic strobe_t strobe_time(row_req_t rq, logic [1:0] rank);
    strobe_t s;
    longint unsigned ohms;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    longint tfac;
    ohms = (rank == 2'd0) ? 190 : (rank == 2'd1) ? 177 : (rank == 2'd2) ? 164 : 150;
    tfac = 12200 - 11 * longint'(rq.temp);
    if (rq.mv == 0) begin
      s.us = 16'hffff; s.clamped = 1'b1;
    end else if (tfac < 0) begin
      s.us = '0; s.clamped = 1'b1;
    end else begin
      num = 264 + 10 * ohms;
      num = 23 * num * num * longint'(tfac);
      num = num * (100 + corr_pct(rq.mv, rq.temp)) * (100 + rq.rows / 64);
      den = 1000 * ohms * rq.mv * rq.mv;
      q = num / den;
      if (q > 65535) begin
        s.us = 16'hffff; s.clamped = 1'b1;
      end else begin
        s.us = q[15:0]; s.clamped = 1'b0;
      end
    end
    return s;
  endfunction

  function automatic row_req_t random_row();
    row_req_t rq;
    case ($urandom_range(0, 9))
      0: rq.mv = 14'($urandom);
      1: rq.mv = 14'($urandom_range(0, 1500));
      default: rq.mv = 14'($urandom_range(4100, 8600));
    endcase
    case ($urandom_range(0, 9))
      0: rq.temp = 12'($urandom);
      1: rq.temp = 12'($urandom_range(1100, 1250));
      default: rq.temp = $signed(12'($urandom_range(0, 800))) - 12'sd60;
    endcase
    rq.rows = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 384));
    return rq;
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (push && !full) begin
      expected_strobes.push_back(strobe_time(pending_rows.pop_front(), rank_now));
    end
    if (!driver_on || pending_rows.size() == 0 ||
        (push && !full && pending_rows.size() == 0)) begin
      push <= 1'b0;
    end else if (push && full) begin
      push <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      push <= 1'b0;
    end else begin
      supply_mv_i <= pending_rows[0].mv;
      temp_decideg_i <= pending_rows[0].temp;
      row_sum_i <= pending_rows[0].rows;
      push <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i) begin
    strobe_t exp_s;
    if (pop && !empty) begin
      if (expected_strobes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction us=%0d clamped=%0b",
                                       strobe_us_o, clamped_o);
      end else begin
        exp_s = expected_strobes.pop_front();
        if (strobe_us_o !== exp_s.us || clamped_o !== exp_s.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected us=%0d clamped=%0b, got us=%0d clamped=%0b",
                     exp_s.us, exp_s.clamped, strobe_us_o, clamped_o);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 7) < 5) || (($urandom & 32'h300) == 32'h300);
    end
  end

  task automatic drain();
    while (pending_rows.size() != 0 || push || expected_strobes.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_rank(logic [1:0] r);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    rank_now = r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [1:0] ranks[5];
    ranks = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    driver_on = 1'b1;
    // directed: zero supply, hot head, smallest positive factor, table edges, field extremes
    pending_rows.push_back('{14'd0, 12'sd0, 9'd0});
    pending_rows.push_back('{14'd0, 12'sd2000, 9'd511});
    pending_rows.push_back('{14'd5000, 12'sd1110, 9'd100});
    pending_rows.push_back('{14'd5000, 12'sd1109, 9'd100});
    pending_rows.push_back('{14'd5000, 12'sd1111, 9'd100});
    pending_rows.push_back('{14'd1, 12'sd0, 9'd0});
    pending_rows.push_back('{14'h3fff, -12'sd2048, 9'd511});
    pending_rows.push_back('{14'h3fff, 12'sd2047, 9'd0});
    pending_rows.push_back('{14'd4199, -12'sd50, 9'd63});
    pending_rows.push_back('{14'd4200, -12'sd50, 9'd64});
    pending_rows.push_back('{14'd4200, -12'sd51, 9'd384});
    pending_rows.push_back('{14'd4500, 12'sd50, 9'd128});
    pending_rows.push_back('{14'd4501, 12'sd51, 9'd192});
    pending_rows.push_back('{14'd8500, 12'sd700, 9'd256});
    pending_rows.push_back('{14'd8501, 12'sd701, 9'd320});
    pending_rows.push_back('{14'd6000, 12'sd350, 9'd448});
    pending_rows.push_back('{14'd7000, 12'sd500, 9'd1});
    pending_rows.push_back('{14'd12000, -12'sd400, 9'd384});
    pending_rows.push_back('{14'd12000, 12'sd1250, 9'd0});
    drain();
    foreach (ranks[p]) begin
      set_rank(ranks[p]);
      if (p == 2) begin
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) pending_rows.push_back(random_row());
      end
      for (int i = 0; i < 350; i++) pending_rows.push_back(random_row());
      drain();
    end
    if (mismatches == 0 && expected_strobes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ----- files.f -----
design/thst_pkg.sv
design/thst_front.sv
design/thst_fifo.sv
design/thst_back.sv
design/thermal_head_strobe_time_core.sv
tb/tb_thermal_head_strobe_time_core.sv
